/* rtl/core/bfm_pkg.sv */
// Shared types, constants and the hash multiply for the two-level Bloom filter.
// Used by every module of the block; no dependencies.
package bfm_pkg;

  localparam logic [63:0] MUR_M        = 64'hc6a4a7935bd1e995;
  localparam int          MUR_R        = 47;
  localparam int          NUM_SEEDS    = 8;
  localparam int          SEED_W       = 3;
  localparam int          ARRAY_WORDS  = 16384;
  localparam int          ADDR_W       = 14;
  localparam int          IDX_W        = 20;
  localparam int          FIFO_DEPTH   = 4;
  localparam int          FIFO_PTR_W   = 2;
  localparam logic [8:0]  MAX_LEN      = 9'd256;
  localparam logic [17:0] MAX_FB       = 18'd131072;
  localparam logic [3:0]  MAX_HASH_CNT = 4'd8;

  localparam logic [1:0] REG_READ_BYTES   = 2'd0;
  localparam logic [1:0] REG_NUM_HASHES   = 2'd1;
  localparam logic [1:0] REG_FILTER_BYTES = 2'd2;

  typedef enum logic [1:0] {
    MIX_NONE = 2'd0,
    MIX_FULL = 2'd1,
    MIX_TAIL = 2'd2
  } mix_kind_t;

  typedef struct packed {
    logic [8:0]  read_bytes;
    logic [3:0]  n_hashes;
    logic [17:0] filter_bytes;
  } bfm_cfg_t;

  typedef struct packed {
    logic [63:0] word;
    logic [8:0]  len;
    mix_kind_t   kind;
    logic        op;
    logic        first;
    logic        last;
  } bfm_ent_t;

  // x * MUR_M modulo 2^64 from three 32x32 partial products
  function automatic logic [63:0] mulm(input logic [63:0] x);
    logic [63:0] p0;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [31:0] hi;
    p0 = x[31:0] * MUR_M[31:0];
    p1 = x[31:0] * MUR_M[63:32];
    p2 = x[63:32] * MUR_M[31:0];
    hi = p1[31:0] + p2[31:0];
    return p0 + {hi, 32'd0};
  endfunction

endpackage

/* rtl/core/bfm_front.sv */
// Front end: accepts read words, tracks the word position and classifies each word.
// Depends on bfm_pkg.
module bfm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  bfm_pkg::bfm_cfg_t cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,
  input  logic [0:0]        in_tuser,
  input  logic              q_full,
  output logic              q_push,
  output bfm_pkg::bfm_ent_t q_data
);
  import bfm_pkg::*;

  logic [5:0] wc_r, wc_nxt;
  logic [8:0] len;
  logic [5:0] full_w;
  logic [2:0] tail;
  logic [5:0] words;
  logic [6:0] wc_inc;
  logic [63:0] mask;
  logic        last;

  always_comb begin
    if (cfg.read_bytes == 9'd0) begin
      len = 9'd1;
    end else if (cfg.read_bytes > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = cfg.read_bytes;
    end
    full_w = len[8:3];
    tail   = len[2:0];
    words  = full_w + {5'd0, (tail != 3'd0)};
    wc_inc = {1'b0, wc_r} + 7'd1;
    last   = !(wc_inc < {1'b0, words});
    for (int i = 0; i < 8; i++) begin
      mask[i*8 +: 8] = (i < int'(tail)) ? 8'hff : 8'h00;
    end
  end

  assign in_tready = en && !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_data.len   = len;
    q_data.op    = in_tuser[0];
    q_data.first = (wc_r == 6'd0);
    q_data.last  = last;
    if (wc_r < full_w) begin
      q_data.kind = MIX_FULL;
      q_data.word = in_tdata;
    end else if (tail != 3'd0) begin
      q_data.kind = MIX_TAIL;
      q_data.word = in_tdata & mask;
    end else begin
      q_data.kind = MIX_NONE;
      q_data.word = in_tdata;
    end
  end

  always_comb begin
    wc_nxt = wc_r;
    if (q_push) begin
      wc_nxt = last ? 6'd0 : wc_inc[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= 6'd0;
    end else begin
      wc_r <= wc_nxt;
    end
  end

endmodule

/* rtl/core/bfm_fifo.sv */
// Short queue of classified words between the front end and the hash engine.
// Depends on bfm_pkg.
module bfm_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bfm_pkg::bfm_ent_t push_data,
  output logic              full,
  input  logic              pop,
  output bfm_pkg::bfm_ent_t pop_data,
  output logic              empty
);
  import bfm_pkg::*;

  bfm_ent_t                ent_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wp_r, rp_r;
  logic [FIFO_PTR_W:0]     cnt_r;

  assign full     = (cnt_r == FIFO_PTR_W'(0) + (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

/* rtl/core/bfm_rem.sv */
// Restoring remainder unit, one dividend bit per cycle.
// Depends on bfm_pkg.
module bfm_rem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [60:0] dividend,
  input  logic [17:0] divisor,
  output logic        done,
  output logic [16:0] rem
);
  import bfm_pkg::*;

  logic [60:0] q_r;
  logic [17:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [18:0] trial;
  logic [18:0] diff;

  always_comb begin
    trial = {rem_r, q_r[60]};
    diff  = trial - {1'b0, divisor};
  end

  assign done = done_r;
  assign rem  = rem_r[16:0];

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[59:0], 1'b0};
      rem_r <= (trial >= {1'b0, divisor}) ? diff[17:0] : trial[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd60) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/bfm_back.sv */
// Back end: hash engine with a shared multiplier, index reduction, both bit arrays
// and the result register. Depends on bfm_pkg and bfm_rem.
module bfm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bfm_pkg::bfm_cfg_t cfg,
  input  logic              q_empty,
  input  bfm_pkg::bfm_ent_t q_data,
  output logic              q_pop,
  output logic              clr_busy,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic [0:0]        out_tuser
);
  import bfm_pkg::*;

  typedef enum logic [13:0] {
    ST_CLR  = 14'b00000000000001,
    ST_IDLE = 14'b00000000000010,
    ST_BASE = 14'b00000000000100,
    ST_MIX  = 14'b00000000001000,
    ST_K1   = 14'b00000000010000,
    ST_K2   = 14'b00000000100000,
    ST_ACC  = 14'b00000001000000,
    ST_F1   = 14'b00000010000000,
    ST_F2   = 14'b00000100000000,
    ST_DIV  = 14'b00001000000000,
    ST_TRD  = 14'b00010000000000,
    ST_TCK  = 14'b00100000000000,
    ST_SRD  = 14'b01000000000000,
    ST_SWR  = 14'b10000000000000
  } st_t;

  st_t                st_r, st_nxt;
  logic [3:0]         s_r;
  logic [ADDR_W-1:0]  clr_r;
  logic [63:0]        k_r, h_r;
  logic [63:0]        acc_r [NUM_SEEDS];
  logic [IDX_W-1:0]   idx_r [NUM_SEEDS];
  logic [2:0]         lo3_r;
  logic               all_r;
  bfm_ent_t           ent_r;
  logic               out_valid_r, found_r, opd_r;
  logic               wait_out;
  logic               out_set;

  logic [63:0]        once_mem  [ARRAY_WORDS];
  logic [63:0]        twice_mem [ARRAY_WORDS];
  logic [63:0]        once_rd_r, twice_rd_r;

  logic [3:0]         n_eff;
  logic [17:0]        fb_eff;
  logic [63:0]        mul_a, prod, acc_s, hx;
  logic [IDX_W-1:0]   idx_s;
  logic [ADDR_W-1:0]  raddr, waddr;
  logic               we_once, we_twice;
  logic [63:0]        wd_once, wd_twice, bit_mask;
  logic               div_start, div_done;
  logic [16:0]        div_rem;
  logic               s_more;
  logic               bit_hit;

  always_comb begin
    if (cfg.n_hashes == 4'd0) begin
      n_eff = 4'd1;
    end else if (cfg.n_hashes > MAX_HASH_CNT) begin
      n_eff = MAX_HASH_CNT;
    end else begin
      n_eff = cfg.n_hashes;
    end
    if (cfg.filter_bytes == 18'd0) begin
      fb_eff = 18'd1;
    end else if (cfg.filter_bytes > MAX_FB) begin
      fb_eff = MAX_FB;
    end else begin
      fb_eff = cfg.filter_bytes;
    end
  end

  assign acc_s    = acc_r[s_r[SEED_W-1:0]];
  assign idx_s    = idx_r[s_r[SEED_W-1:0]];
  assign hx       = h_r ^ (h_r >> MUR_R);
  assign s_more   = (s_r + 4'd1) < n_eff;
  assign bit_mask = 64'd1 << idx_s[5:0];
  assign bit_hit  = ent_r.op ? once_rd_r[idx_s[5:0]] : twice_rd_r[idx_s[5:0]];
  assign wait_out = out_valid_r && !out_tready;
  // load a new result once the last seed is tested (query) or set (insert)
  assign out_set  = !s_more && !wait_out &&
                    (((st_r == ST_TCK) && !ent_r.op) || (st_r == ST_SWR));

  // one shared multiplier by the hash constant
  always_comb begin
    unique case (st_r)
      ST_BASE: mul_a = {55'd0, ent_r.len};
      ST_K1:   mul_a = ent_r.word;
      ST_K2:   mul_a = k_r ^ (k_r >> MUR_R);
      ST_ACC:  mul_a = acc_s ^ k_r;
      ST_F1:   mul_a = acc_s ^ (acc_s >> MUR_R);
      default: mul_a = 64'd0;
    endcase
    prod = mulm(mul_a);
  end

  always_comb begin
    raddr     = idx_s[IDX_W-1:6];
    waddr     = idx_s[IDX_W-1:6];
    we_once   = 1'b0;
    we_twice  = 1'b0;
    wd_once   = once_rd_r | bit_mask;
    wd_twice  = twice_rd_r | bit_mask;
    if (st_r == ST_CLR) begin
      waddr    = clr_r;
      we_once  = 1'b1;
      we_twice = 1'b1;
      wd_once  = 64'd0;
      wd_twice = 64'd0;
    end else if (st_r == ST_SWR) begin
      we_once  = 1'b1;
      we_twice = all_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we_once) begin
      once_mem[waddr] <= wd_once;
    end
    if (we_twice) begin
      twice_mem[waddr] <= wd_twice;
    end
    once_rd_r  <= once_mem[raddr];
    twice_rd_r <= twice_mem[raddr];
  end

  assign div_start = (st_r == ST_F2);

  bfm_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (hx[63:3]),
    .divisor  (fb_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign q_pop    = (st_r == ST_IDLE) && !q_empty;
  assign clr_busy = (st_r == ST_CLR);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLR:  if (clr_r == '1) st_nxt = ST_IDLE;
      ST_IDLE: if (!q_empty) st_nxt = q_data.first ? ST_BASE : ST_MIX;
      ST_BASE: st_nxt = ST_MIX;
      ST_MIX: begin
        unique case (ent_r.kind)
          MIX_FULL: st_nxt = ST_K1;
          MIX_TAIL: st_nxt = ST_ACC;
          default:  st_nxt = ent_r.last ? ST_F1 : ST_IDLE;
        endcase
      end
      ST_K1:   st_nxt = ST_K2;
      ST_K2:   st_nxt = ST_ACC;
      ST_ACC:  if (s_r == 4'(NUM_SEEDS - 1)) st_nxt = ent_r.last ? ST_F1 : ST_IDLE;
      ST_F1:   st_nxt = ST_F2;
      ST_F2:   st_nxt = ST_DIV;
      ST_DIV:  if (div_done) st_nxt = s_more ? ST_F1 : ST_TRD;
      ST_TRD:  st_nxt = ST_TCK;
      ST_TCK: begin
        if (s_more) begin
          st_nxt = ST_TRD;
        end else if (ent_r.op) begin
          st_nxt = ST_SRD;
        end else if (!wait_out) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_SRD:  st_nxt = ST_SWR;
      ST_SWR: begin
        if (s_more) begin
          st_nxt = ST_SRD;
        end else if (!wait_out) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_data;
    end
    unique case (st_r)
      ST_BASE: begin
        for (int i = 0; i < NUM_SEEDS; i++) begin
          acc_r[i] <= {prod[63:3], prod[2:0] ^ SEED_W'(i)};
        end
      end
      ST_MIX:  k_r <= ent_r.word;
      ST_K1:   k_r <= prod;
      ST_K2:   k_r <= prod;
      ST_ACC:  acc_r[s_r[SEED_W-1:0]] <= prod;
      ST_F1:   h_r <= prod;
      ST_F2:   lo3_r <= hx[2:0];
      ST_DIV:  if (div_done) idx_r[s_r[SEED_W-1:0]] <= {div_rem, lo3_r};
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_r       <= '0;
      s_r         <= '0;
      all_r       <= 1'b1;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      opd_r       <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      priority case (1'b1)
        (st_r == ST_MIX), (st_r == ST_K2): s_r <= '0;
        (st_r == ST_ACC): begin
          s_r <= (s_r == 4'(NUM_SEEDS - 1)) ? 4'd0 : s_r + 4'd1;
        end
        (st_r == ST_DIV): begin
          if (div_done) begin
            s_r   <= s_more ? s_r + 4'd1 : 4'd0;
            all_r <= 1'b1;
          end
        end
        (st_r == ST_TCK): begin
          all_r <= all_r & bit_hit;
          if (s_more) begin
            s_r <= s_r + 4'd1;
          end else if (ent_r.op) begin
            s_r <= '0;
          end else if (!wait_out) begin
            found_r <= all_r & bit_hit;
            opd_r   <= ent_r.op;
          end
        end
        (st_r == ST_SWR): begin
          if (s_more) begin
            s_r <= s_r + 4'd1;
          end else if (!wait_out) begin
            found_r <= all_r;
            opd_r   <= ent_r.op;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, found_r};
  assign out_tuser  = opd_r;

  a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_F1) |-> (s_r < n_eff))
    else $error("final hash seed beyond hash count");

endmodule

/* rtl/core/two_level_bloom_filter_murmur64_unit.sv */
// Top level of the two-level Bloom filter keyed by MurmurHash64A: config registers,
// front end, word queue and back end. Depends on bfm_pkg, bfm_front, bfm_fifo, bfm_back.
//
//  port group  direction  payload
//  in_*        slave      tdata = read_word[63:0], tuser = opcode
//  out_*       master     tdata = {7'b0, found}, tuser = op_done
//  cfg_*       APB slave  0x0 read_bytes, 0x4 number of hashes, 0x8 filter_bytes
//
// Each word passes the shared multiplier in the K1, K2 and ACC steps (full) or in ACC only
// (tail), after a BASE step when it opens a read. The final word then runs, per seed, F1, F2
// and the bit-serial index remainder, then a test of each seed's bit and, on insert, a bit set.
// After reset both bit arrays are swept clear, all 16384 words, with in_tready low.
// The four-entry queue keeps taking words while the back end works or the result waits.
module two_level_bloom_filter_murmur64_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // read_word[63:0]
  input  logic [0:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // found, then zero fill
  output logic [0:0]  out_tuser,  // op_done
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bfm_pkg::*;

  bfm_cfg_t cfg_r;
  logic     wr_en;
  logic     clr_busy;
  logic     q_push, q_pop, q_full, q_empty;
  bfm_ent_t q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_bytes   <= 9'd8;
      cfg_r.n_hashes     <= 4'd3;
      cfg_r.filter_bytes <= 18'd131072;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_READ_BYTES:   cfg_r.read_bytes   <= cfg_pwdata[8:0];
        REG_NUM_HASHES:   cfg_r.n_hashes     <= cfg_pwdata[3:0];
        REG_FILTER_BYTES: cfg_r.filter_bytes <= cfg_pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_READ_BYTES:   cfg_prdata = {23'd0, cfg_r.read_bytes};
      REG_NUM_HASHES:   cfg_prdata = {28'd0, cfg_r.n_hashes};
      REG_FILTER_BYTES: cfg_prdata = {14'd0, cfg_r.filter_bytes};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  bfm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (!clr_busy),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  bfm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  bfm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .clr_busy   (clr_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* sim/tb_two_level_bloom_filter_murmur64_unit.sv */
// Testbench for two_level_bloom_filter_murmur64_unit: streams reads under several
// register settings and checks every result against a built-in predictor.
// Depends on bfm_pkg and the block's RTL.
module tb_two_level_bloom_filter_murmur64_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bfm_pkg::*;

  localparam logic [63:0] MIX_K    = 64'hc6a4a7935bd1e995;
  localparam int          ARR_W    = 16384;
  localparam int          SETTLE   = 1200;
  localparam int          WD_LIMIT = 60000;
  localparam int          NPHASE   = 9;

  typedef struct {
    bit found;
    bit op;
  } bloom_answer_t;

  class bloom_scoreboard;
    bit [8:0]      read_len;
    bit [3:0]      num_hashes;
    bit [17:0]     filt_bytes;
    bit [63:0]     lane_hash[8];
    int unsigned   words_taken;
    bit [63:0]     once_bits[ARR_W];
    bit [63:0]     twice_bits[ARR_W];
    bloom_answer_t pending_answers[$];
    int unsigned   errors;
    int unsigned   checked;

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_READ_BYTES:   read_len = val[8:0];
        REG_NUM_HASHES:   num_hashes = val[3:0];
        REG_FILTER_BYTES: filt_bytes = val[17:0];
        default: ;
      endcase
    endfunction

    function void reset_state();
      read_len = 9'd8;
      num_hashes = 4'd3;
      filt_bytes = 18'd131072;
      words_taken = 0;
      errors = 0;
      checked = 0;
    endfunction

    // fold one accepted word into the running seed hashes; predict on the last word
    function void note_word(bit op, bit [63:0] word);
      int unsigned len, full, tail, nwords, n;
      bit [63:0] k, h, modulus;
      bit [19:0] bidx[8];
      bit all_set;
      len = (read_len == 0) ? 1 : (read_len > 256) ? 256 : read_len;
      full = len / 8;
      tail = len % 8;
      nwords = full + (tail != 0);
      if (words_taken == 0)
        for (int s = 0; s < 8; s++) lane_hash[s] = 64'(s) ^ (64'(len) * MIX_K);
      if (words_taken < full) begin
        k = word * MIX_K;
        k ^= k >> 47;
        k = k * MIX_K;
        for (int s = 0; s < 8; s++) lane_hash[s] = (lane_hash[s] ^ k) * MIX_K;
      end else if (tail != 0) begin
        k = word & ((64'd1 << (tail * 8)) - 64'd1);
        for (int s = 0; s < 8; s++) lane_hash[s] = (lane_hash[s] ^ k) * MIX_K;
      end
      words_taken++;
      if (words_taken < nwords) begin
        words_taken &= 63;
        return;
      end
      words_taken = 0;
      n = (num_hashes == 0) ? 1 : (num_hashes > 8) ? 8 : num_hashes;
      modulus = 64'((filt_bytes == 0) ? 1 : (filt_bytes > 131072) ? 131072 : filt_bytes) * 8;
      for (int s = 0; s < n; s++) begin
        h = lane_hash[s];
        h ^= h >> 47;
        h = h * MIX_K;
        h ^= h >> 47;
        bidx[s] = 20'(h % modulus);
      end
      all_set = 1;
      // check every bit before setting any so repeated indices behave
      for (int s = 0; s < n; s++)
        if (op) begin
          if (!once_bits[bidx[s][19:6]][bidx[s][5:0]]) all_set = 0;
        end else begin
          if (!twice_bits[bidx[s][19:6]][bidx[s][5:0]]) all_set = 0;
        end
      if (op) begin
        for (int s = 0; s < n; s++) once_bits[bidx[s][19:6]][bidx[s][5:0]] = 1;
        if (all_set)
          for (int s = 0; s < n; s++) twice_bits[bidx[s][19:6]][bidx[s][5:0]] = 1;
      end
      pending_answers.push_back('{found: all_set, op: op});
    endfunction

    function void check_result(bit found, bit op);
      bloom_answer_t exp_ans;
      if (pending_answers.size() == 0) begin
        $error("unexpected result: found=%0d op_done=%0d", found, op);
        errors++;
        return;
      end
      exp_ans = pending_answers.pop_front();
      checked++;
      if (found !== exp_ans.found) begin
        $error("found: expected %0d, got %0d", exp_ans.found, found);
        errors++;
      end
      if (op !== exp_ans.op) begin
        $error("op_done: expected %0d, got %0d", exp_ans.op, op);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // read_word[63:0]
  logic [0:0]  in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // found, then zero fill
  logic [0:0]  out_tuser;  // op_done
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  two_level_bloom_filter_murmur64_unit i_dut (.*);

  bloom_scoreboard sb = new();
  bit          quiet;
  int unsigned words_sent;
  int unsigned stall_left;
  int unsigned idle_cycles;
  bit [63:0]   key_pool[6][32];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    sb.reset_state();
  end

  // result side: check accepted results and stall in bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata[0], out_tuser[0]);
      if (quiet) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("FAIL two_level_bloom_filter_murmur64_unit");
      $finish;
    end
  end

  task automatic send_word(bit op, bit [63:0] word);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(op, word);
    words_sent++;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every predicted result is back, then let the back end settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int unsigned read_words();
    int unsigned len;
    len = (sb.read_len == 0) ? 1 : (sb.read_len > 256) ? 256 : sb.read_len;
    return (len + 7) / 8;
  endfunction

  task automatic send_read(bit op, int pool_sel);
    int unsigned nw;
    nw = read_words();
    for (int w = 0; w < nw; w++)
      send_word((w == nw - 1) ? op : 1'($urandom),
                (pool_sel < 0) ? {$urandom, $urandom} : key_pool[pool_sel][w]);
  endtask

  int unsigned ph_len[NPHASE]   = '{1, 0, 13, 20, 7, 256, 511, 24, 8};
  int unsigned ph_hash[NPHASE]  = '{1, 0, 8, 4, 2, 8, 15, 5, 3};
  int unsigned ph_fb[NPHASE]    = '{1, 0, 2, 64, 8, 131072, 262143, 512, 131072};
  int unsigned ph_items[NPHASE] = '{150, 100, 200, 250, 200, 80, 70, 250, 300};

  initial begin
    int unsigned start;
    words_sent = 0;
    stall_left = 0;
    idle_cycles = 0;
    quiet = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: one-word reads under the reset setting
    send_word(1'b1, 64'h0);
    send_word(1'b1, 64'h0);
    send_word(1'b0, 64'h0);
    send_word(1'b0, '1);
    send_word(1'b1, '1);
    send_word(1'b0, '1);
    send_word(1'b1, '1);
    send_word(1'b0, '1);
    send_word(1'b0, 64'h0);
    send_word(1'b1, 64'h8000_0000_0000_0001);
    send_word(1'b0, 64'h8000_0000_0000_0001);
    drain();

    for (int p = 0; p < NPHASE; p++) begin
      quiet = (p == NPHASE - 1);
      cfg_write(REG_READ_BYTES, ph_len[p]);
      cfg_write(REG_NUM_HASHES, ph_hash[p]);
      cfg_write(REG_FILTER_BYTES, ph_fb[p]);
      for (int i = 0; i < 6; i++)
        for (int w = 0; w < 32; w++) key_pool[i][w] = {$urandom, $urandom};
      start = words_sent;
      while (words_sent - start < ph_items[p]) begin
        // mostly repeat pooled keys so inserts reach the second array
        if ($urandom_range(0, 9) < 7) send_read(1'($urandom), $urandom_range(0, 5));
        else send_read(1'($urandom), -1);
      end
      drain();
    end

    $display("Ran %0d words and checked %0d results over %0d register settings,",
             words_sent, sb.checked, NPHASE + 1);
    $display("including zero and oversize lengths, hash counts and filter sizes.");
    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("PASS two_level_bloom_filter_murmur64_unit");
    end else begin
      $display("FAIL two_level_bloom_filter_murmur64_unit");
    end
    $finish;
  end
endmodule
